// ===== rtl/assert_macros.svh =====
// Assertion macros for the point cloud block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/dpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types and constants of the depth to point cloud block.
// ----------------------------------------------------------------------------
`default_nettype none
package dpc_pkg;
	localparam int unsigned MAX_IMAGE_SIDE = 4096;
	localparam int unsigned COORD_W = $clog2(MAX_IMAGE_SIDE);
	localparam int unsigned SIDE_W = COORD_W + 1;
	localparam logic [7:0] COLOR_FULL = 8'd255;

	// beat opcodes
	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	localparam logic [2:0] REG_WIDTH = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_FRONT = 3'd2;
	localparam logic [2:0] REG_BACK = 3'd3;
	localparam logic [2:0] REG_WALL = 3'd4;
	localparam logic [2:0] REG_PF = 3'd5;
	localparam logic [2:0] REG_DF = 3'd6;
	localparam logic [2:0] REG_COLOR = 3'd7;

	localparam logic [1:0] CM_INPUT = 2'd0;
	localparam logic [1:0] CM_WHITE = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_MUL2, ST_DIV, ST_FIN, ST_OUT
	} dpc_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic mul2;
		logic div_start;
		logic div_step;
		logic fin;
	} dpc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_scan;
		logic in_range;
		logic div_done;
	} dpc_stat_t;
endpackage
`default_nettype wire

// ===== rtl/depth_to_point_cloud.sv =====
// Sequencing: a scan beat or an out-of-range emit beat passes through
// ST_MUL and returns to idle with no output; a vertex beat passes through
// ST_MUL, ST_MUL2, the 24-step hue divider, ST_FIN and ST_OUT to out_valid.
// A new beat is taken only in idle, once the previous beat has finished.
// Reset: arst_n asynchronous active low; restores register defaults and
// clears the frame maximum.
// ----------------------------------------------------------------------------
// depth_to_point_cloud
// Unprojects depth pixels to colored Q.16 vertices.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module depth_to_point_cloud
	import dpc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [2:0] cfg_index,
	input wire logic [23:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic opcode,
	input wire logic first_of_frame,
	input wire logic [COORD_W-1:0] pixel_x,
	input wire logic [COORD_W-1:0] pixel_y,
	input wire logic [15:0] depth,
	input wire logic [7:0] red_in,
	input wire logic [7:0] green_in,
	input wire logic [7:0] blue_in,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [47:0] vertex_x,
	output logic signed [47:0] vertex_y,
	output logic [39:0] vertex_z,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);
	dpc_cmd_t cmd;
	dpc_stat_t stat;

	dpc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .out_stall, .stat,
		.in_stall, .out_valid, .cmd
	);

	dpc_datapath u_dp (
		.clk, .arst_n, .cfg_write, .cfg_index, .cfg_data, .cmd, .stat,
		.opcode, .first_of_frame, .pixel_x, .pixel_y, .depth,
		.red_in, .green_in, .blue_in,
		.vertex_x, .vertex_y, .vertex_z, .red_out, .green_out, .blue_out
	);

	// no input taken while a result is pending
	`ASSERT_IMPLIES(a_no_overlap, clk, arst_n, out_valid, in_stall)
	// a held result stays until taken
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid)
	// an accepted beat starts the sequence
	`ASSERT_NEXT(a_load, clk, arst_n, in_valid && !in_stall, in_stall)
endmodule
`default_nettype wire

// ===== rtl/dpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpc_ctrl
// Sequencer: load, multiply, divide for hue, finish, hold result.
// ----------------------------------------------------------------------------
`default_nettype none
module dpc_ctrl
	import dpc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic out_stall,
	input wire dpc_stat_t stat,
	output logic in_stall,
	output logic out_valid,
	output dpc_cmd_t cmd
);
	dpc_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MUL;
			ST_MUL: begin
				if (stat.is_scan || !stat.in_range) state_d = ST_IDLE;
				else state_d = ST_MUL2;
			end
			ST_MUL2: state_d = ST_DIV;
			ST_DIV: if (stat.div_done) state_d = ST_FIN;
			ST_FIN: state_d = ST_OUT;
			ST_OUT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_MUL: cmd.mul = 1'b1;
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_DIV: cmd.div_step = 1'b1;
			ST_FIN: cmd.fin = 1'b1;
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/dpc_datapath.sv =====
// ----------------------------------------------------------------------------
// dpc_datapath
// Config registers, frame maximum, multipliers, serial hue divider, color.
// ----------------------------------------------------------------------------
`default_nettype none
module dpc_datapath
	import dpc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [2:0] cfg_index,
	input wire logic [23:0] cfg_data,
	input wire dpc_cmd_t cmd,
	output dpc_stat_t stat,
	input wire logic opcode,
	input wire logic first_of_frame,
	input wire logic [COORD_W-1:0] pixel_x,
	input wire logic [COORD_W-1:0] pixel_y,
	input wire logic [15:0] depth,
	input wire logic [7:0] red_in,
	input wire logic [7:0] green_in,
	input wire logic [7:0] blue_in,
	output logic signed [47:0] vertex_x,
	output logic signed [47:0] vertex_y,
	output logic [39:0] vertex_z,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);
	logic [SIDE_W-1:0] width_q, height_q;
	logic [15:0] front_q, back_q, wall_q, max_q;
	logic [19:0] pf_q;
	logic [23:0] df_q;
	logic [1:0] cmode_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SIDE_W'(640);
			height_q <= SIDE_W'(480);
			front_q <= '0;
			back_q <= 16'hFFFF;
			wall_q <= '0;
			pf_q <= '0;
			df_q <= 24'd65536;
			cmode_q <= CM_INPUT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WIDTH: width_q <= cfg_data[SIDE_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[SIDE_W-1:0];
				REG_FRONT: front_q <= cfg_data[15:0];
				REG_BACK: back_q <= cfg_data[15:0];
				REG_WALL: wall_q <= cfg_data[15:0];
				REG_PF: pf_q <= cfg_data[19:0];
				REG_DF: df_q <= cfg_data;
				REG_COLOR: cmode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// latched item
	logic scan_q, first_q;
	logic [COORD_W-1:0] px_q, py_q;
	logic [15:0] z_q;
	logic [7:0] r_q, g_q, b_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			scan_q <= (opcode == OP_SCAN);
			first_q <= first_of_frame;
			px_q <= pixel_x;
			py_q <= pixel_y;
			z_q <= depth;
			r_q <= red_in;
			g_q <= green_in;
			b_q <= blue_in;
		end
	end

	// missing depth substitute
	logic [15:0] zs;
	assign zs = (z_q != '0) ? z_q : ((max_q > wall_q) ? max_q : wall_q);
	assign stat.is_scan = scan_q;
	assign stat.in_range = (zs > front_q) && (zs < back_q);

	// frame maximum, updated by scan items
	logic [15:0] base_max;
	assign base_max = first_q ? 16'd0 : max_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_q <= '0;
		else if (cmd.mul && scan_q) max_q <= (z_q > base_max) ? z_q : base_max;
	end

	// first products: pf*z, df*z, center offsets
	logic [35:0] scaled_q;
	logic signed [SIDE_W:0] offx_q, offy_q;
	logic [15:0] zv_q;
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			scaled_q <= 36'(pf_q) * 36'(zs);
			vertex_z <= 40'(40'(df_q) * 40'(zs));
			offx_q <= $signed({2'b0, px_q}) - $signed({2'b0, width_q[SIDE_W-1:1]});
			offy_q <= $signed({2'b0, py_q}) - $signed({2'b0, height_q[SIDE_W-1:1]});
			zv_q <= zs;
		end
	end

	// second products: offset times scale, then saturation
	logic signed [50:0] px_s2, py_s2;
	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			px_s2 <= 51'(offx_q) * $signed({15'b0, scaled_q});
			py_s2 <= 51'(offy_q) * $signed({15'b0, scaled_q});
		end
	end

	function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
		logic signed [50:0] hi, lo;
		hi = 51'sh7FFFFFFFFFFF;
		lo = -hi - 51'sd1;
		if (v > hi) sat48 = 48'sh7FFFFFFFFFFF;
		else if (v < lo) sat48 = 48'sh800000000000;
		else sat48 = v[47:0];
	endfunction

	// restoring divider: z*255 / max, one quotient bit per cycle
	logic [23:0] dnum_q;
	logic [16:0] drem_q;
	logic [23:0] quo_q;
	logic [4:0] dcnt_q;
	logic [17:0] trial;
	assign trial = {drem_q, dnum_q[23]} - {2'b0, max_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (cmd.div_start) begin
			dnum_q <= 24'(zv_q) * 24'(COLOR_FULL);
			drem_q <= '0;
			dcnt_q <= 5'd24;
		end else if (cmd.div_step && dcnt_q != '0) begin
			if (!trial[17]) begin
				drem_q <= trial[16:0];
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				drem_q <= {drem_q[15:0], dnum_q[23]};
				quo_q <= {quo_q[22:0], 1'b0};
			end
			dnum_q <= {dnum_q[22:0], 1'b0};
			dcnt_q <= dcnt_q - 5'd1;
		end
	end
	assign stat.div_done = (dcnt_q == 5'd1);

	// hue to color
	logic [7:0] hue;
	logic [10:0] six;
	logic [2:0] sector;
	logic [7:0] t, q;
	always_comb begin
		if (max_q == '0) hue = '0;
		else if (quo_q > 24'd255) hue = COLOR_FULL;
		else hue = quo_q[7:0];
		six = 11'(hue) * 11'd6;
		if (six >= 11'd1530) sector = 3'd6;
		else if (six >= 11'd1275) sector = 3'd5;
		else if (six >= 11'd1020) sector = 3'd4;
		else if (six >= 11'd765) sector = 3'd3;
		else if (six >= 11'd510) sector = 3'd2;
		else if (six >= 11'd255) sector = 3'd1;
		else sector = 3'd0;
		t = 8'(six - 11'(sector) * 11'd255);
		q = COLOR_FULL - t;
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			vertex_x <= sat48(px_s2);
			vertex_y <= sat48(py_s2);
			if (cmode_q == CM_INPUT) begin
				red_out <= r_q; green_out <= g_q; blue_out <= b_q;
			end else if (cmode_q == CM_WHITE) begin
				red_out <= COLOR_FULL; green_out <= COLOR_FULL; blue_out <= COLOR_FULL;
			end else begin
				unique case (sector)
					3'd0: begin red_out <= COLOR_FULL; green_out <= t; blue_out <= '0; end
					3'd1: begin red_out <= q; green_out <= COLOR_FULL; blue_out <= '0; end
					3'd2: begin red_out <= '0; green_out <= COLOR_FULL; blue_out <= t; end
					3'd3: begin red_out <= '0; green_out <= q; blue_out <= COLOR_FULL; end
					3'd4: begin red_out <= t; green_out <= '0; blue_out <= COLOR_FULL; end
					3'd5: begin red_out <= COLOR_FULL; green_out <= '0; blue_out <= q; end
					default: begin red_out <= COLOR_FULL; green_out <= '0; blue_out <= '0; end
				endcase
			end
		end
	end
endmodule
`default_nettype wire
